### design/gld_pkg.sv
// Shared types and constants for the GIF LZW decoder.
`default_nettype none
package gld_pkg;

  // Request codes as they arrive on the input channel.
  localparam logic [1:0] REQ_PUSH  = 2'd0;
  localparam logic [1:0] REQ_PULL  = 2'd1;
  localparam logic [1:0] REQ_START = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_NEED    = 3'd2;
  localparam logic [2:0] ST_END     = 3'd3;
  localparam logic [2:0] ST_CORRUPT = 3'd4;

  // Root size limits and reset value.
  localparam logic [3:0] ROOT_MIN   = 4'd2;
  localparam logic [3:0] ROOT_MAX   = 4'd8;
  localparam logic [3:0] ROOT_RESET = 4'd8;

  // Classified command handed from the front end to the engine.
  typedef enum logic [1:0] {
    CMD_PUSH,
    CMD_PULL,
    CMD_START,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
  } cmd_t;

  // Engine sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_CHECK,
    S_FETCH,
    S_CODE,
    S_WALK_CHK,
    S_WALK
  } eng_state_t;

endpackage
`default_nettype wire

### design/gif_lzw_decoder.sv
// Top level of the GIF LZW decoder: configuration register, front end and engine.
// Push, start and unknown requests are answered from the idle state; a pull served from
// the reversal stack passes through the pop state. A pull that decodes a code reads
// three buffer bytes through the single buffer read port and then walks the code's
// chain through the table, one link a cycle. The first code after a start or a clear
// is returned from the code state with no walk, and any other code ends its walk at
// a root. The later pixels of that chain then come off the stack, one per pull. A
// clear code inside a pull resets the table and returns to the code check. Requests
// queue two deep ahead of the engine and one result waits in the output register.
`default_nettype none
module gif_lzw_decoder
  import gld_pkg::*;
#(
  parameter int MAX_CODE_BITS = 12,
  parameter int BUFFER_BYTES  = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic [3:0] cfg_wr_data,  // min_code_size
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,     // data_byte
  input  wire logic [1:0] in_tuser,     // req_type
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,    // pixel_index
  output logic [2:0]      out_tuser     // status
);

  logic [3:0] min_code_size_r;
  logic       cmd_valid;
  logic       cmd_pop;
  cmd_t       cmd;

  // Root size register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_code_size_r <= ROOT_RESET;
    end else if (cfg_wr_en) begin
      min_code_size_r <= cfg_wr_data;
    end
  end

  gld_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  gld_engine #(
    .MAX_CODE_BITS (MAX_CODE_BITS),
    .BUFFER_BYTES  (BUFFER_BYTES)
  ) u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .min_code_size (min_code_size_r),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_status    (out_tuser),
    .out_pixel     (out_tdata)
  );

endmodule
`default_nettype wire

### design/gld_front.sv
// Front end: accepts request beats, classifies them and queues commands.
`default_nettype none
module gld_front
  import gld_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,
  input  wire logic [1:0] in_tuser,
  output logic            cmd_valid,
  output cmd_t            cmd,
  input  wire logic       cmd_pop
);

  cmd_t       q_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       cls;
  logic       push;

  // Map the request code to a command kind.
  always_comb begin
    cls.data = in_tdata;
    unique case (in_tuser)
      REQ_PUSH:  cls.kind = CMD_PUSH;
      REQ_PULL:  cls.kind = CMD_PULL;
      REQ_START: cls.kind = CMD_START;
      default:   cls.kind = CMD_NOP;
    endcase
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];

  // Queue pointer and fill count update.
  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = cmd_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, cmd_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cls;
    end
  end

  pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n) cmd_pop |-> cmd_valid)
    else $error("command popped from an empty queue");
  fill_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue fill count beyond depth");
  no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !push)
    else $error("beat accepted into a full queue");

endmodule
`default_nettype wire

### design/gld_engine.sv
// Back end: bit buffer, code table, reversal stack and the decode sequencer.
`default_nettype none
module gld_engine
  import gld_pkg::*;
#(
  parameter int MAX_CODE_BITS = 12,
  parameter int BUFFER_BYTES  = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [3:0] min_code_size,
  input  wire logic       cmd_valid,
  input  cmd_t            cmd,
  output logic            cmd_pop,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [2:0]      out_status,
  output logic [7:0]      out_pixel
);

  localparam int TBL   = 1 << MAX_CODE_BITS;
  localparam int CDW   = MAX_CODE_BITS;
  localparam int NW    = MAX_CODE_BITS + 1;
  localparam int BBITS = BUFFER_BYTES * 8;
  localparam int PW    = $clog2(BBITS);
  localparam int CNW   = $clog2(BBITS + 1);
  localparam int BAW   = $clog2(BUFFER_BYTES);
  localparam int SW    = ((PW > CNW) ? PW : CNW) + 1;

  // Memories.
  logic [CDW-1:0] prefix_mem [TBL];
  logic [7:0]     suffix_mem [TBL];
  logic [7:0]     stack_mem  [TBL];
  logic [7:0]     buf_mem    [BUFFER_BYTES];

  logic           tbl_we;
  logic [CDW-1:0] tbl_wa, tbl_ra, pre_q;
  logic [7:0]     suf_q;
  logic           stk_we;
  logic [CDW-1:0] stk_wa, stk_ra;
  logic [7:0]     stk_wd, stk_q;
  logic           buf_we;
  logic [BAW-1:0] buf_wa, buf_ra;
  logic [7:0]     buf_q;

  // Decoder state.
  eng_state_t     state_r, state_nxt;
  logic [3:0]     root_r, root_nxt;
  logic [NW-1:0]  clear_r, clear_nxt;
  logic [3:0]     cw_r, cw_nxt;
  logic [NW-1:0]  nf_r, nf_nxt;
  logic [NW-1:0]  lim_r, lim_nxt;
  logic [7:0]     first_r, first_nxt;
  logic [CDW-1:0] prev_r, prev_nxt;
  logic           fresh_r, fresh_nxt;
  logic           ended_r, ended_nxt;
  logic           term_r, term_nxt;
  logic [7:0]     left_r, left_nxt;
  logic [PW-1:0]  pos_r, pos_nxt;
  logic [CNW-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0]  sp_r, sp_nxt;
  logic [CDW-1:0] wc_r, wc_nxt;
  logic [CDW-1:0] incode_r, incode_nxt;
  logic [23:0]    win_r, win_nxt;
  logic [1:0]     fcnt_r, fcnt_nxt;
  logic [BAW-1:0] ba_r, ba_nxt;

  logic           out_valid_r;
  logic [2:0]     out_status_r;
  logic [7:0]     out_pixel_r;
  logic           emit;
  logic [2:0]     emit_status;
  logic [7:0]     emit_pixel;

  logic           can_go;
  logic [3:0]     root_c;
  logic [NW-1:0]  clear_c;
  logic [SW-1:0]  wsum, psum;
  logic [23:0]    shifted, mask;
  logic [NW-1:0]  code_c, wc_ext, pre_ext, nf_inc;

  function automatic logic [BAW-1:0] next_byte(input logic [BAW-1:0] a);
    next_byte = (a == BAW'(BUFFER_BYTES - 1)) ? '0 : a + 1'b1;
  endfunction

  assign can_go  = cmd_valid && (!out_valid_r || out_tready);
  assign root_c  = (min_code_size < ROOT_MIN) ? ROOT_MIN :
                   ((min_code_size > ROOT_MAX) ? ROOT_MAX : min_code_size);
  assign clear_c = NW'(1) << root_c;

  // Write address of a pushed byte and the read position after a code.
  always_comb begin
    wsum = SW'(pos_r) + SW'(cnt_r);
    if (wsum >= SW'(BBITS)) wsum = wsum - SW'(BBITS);
    psum = SW'(pos_r) + SW'(cw_r);
    if (psum >= SW'(BBITS)) psum = psum - SW'(BBITS);
  end

  // Code extraction from the three fetched bytes.
  assign shifted = win_r >> pos_r[2:0];
  assign mask    = ~(24'hFFFFFF << cw_r);
  assign code_c  = NW'(shifted & mask);
  assign wc_ext  = NW'(wc_r);
  assign pre_ext = NW'(pre_q);
  assign nf_inc  = nf_r + 1'b1;

  // Sequencer next state and datapath control.
  always_comb begin
    state_nxt   = state_r;
    root_nxt    = root_r;
    clear_nxt   = clear_r;
    cw_nxt      = cw_r;
    nf_nxt      = nf_r;
    lim_nxt     = lim_r;
    first_nxt   = first_r;
    prev_nxt    = prev_r;
    fresh_nxt   = fresh_r;
    ended_nxt   = ended_r;
    term_nxt    = term_r;
    left_nxt    = left_r;
    pos_nxt     = pos_r;
    cnt_nxt     = cnt_r;
    sp_nxt      = sp_r;
    wc_nxt      = wc_r;
    incode_nxt  = incode_r;
    win_nxt     = win_r;
    fcnt_nxt    = fcnt_r;
    ba_nxt      = ba_r;
    cmd_pop     = 1'b0;
    emit        = 1'b0;
    emit_status = ST_OK;
    emit_pixel  = 8'd0;
    tbl_we      = 1'b0;
    tbl_wa      = nf_r[CDW-1:0];
    tbl_ra      = wc_r;
    stk_we      = 1'b0;
    stk_wa      = sp_r[CDW-1:0];
    stk_wd      = first_r;
    stk_ra      = sp_r[CDW-1:0] - 1'b1;
    buf_we      = 1'b0;
    buf_wa      = wsum[PW-1:3];
    buf_ra      = ba_r;

    unique case (state_r)
      S_IDLE: begin
        if (can_go) begin
          cmd_pop = 1'b1;
          unique case (cmd.kind)
            CMD_START: begin
              emit      = 1'b1;
              root_nxt  = root_c;
              clear_nxt = clear_c;
              cw_nxt    = root_c + 4'd1;
              nf_nxt    = clear_c + NW'(2);
              lim_nxt   = clear_c << 1;
              sp_nxt    = '0;
              pos_nxt   = '0;
              cnt_nxt   = '0;
              left_nxt  = 8'd0;
              term_nxt  = 1'b0;
              first_nxt = 8'd0;
              prev_nxt  = '0;
              fresh_nxt = 1'b1;
              ended_nxt = 1'b0;
            end
            CMD_PUSH: begin
              emit = 1'b1;
              if (term_r) begin
                emit_status = ST_END;
              end else if (left_r == 8'd0) begin
                if (cmd.data == 8'd0) term_nxt = 1'b1;
                else                  left_nxt = cmd.data;
              end else if (ended_r) begin
                left_nxt = left_r - 8'd1;
              end else if (cnt_r > CNW'(BBITS - 8)) begin
                emit_status = ST_FULL;
              end else begin
                buf_we   = 1'b1;
                cnt_nxt  = cnt_r + CNW'(8);
                left_nxt = left_r - 8'd1;
              end
            end
            CMD_PULL: begin
              if (ended_r) begin
                emit        = 1'b1;
                emit_status = ST_END;
              end else if (sp_r != '0) begin
                sp_nxt    = sp_r - 1'b1;
                state_nxt = S_POP;
              end else begin
                state_nxt = S_CHECK;
              end
            end
            default: emit = 1'b1;
          endcase
        end
      end

      S_POP: begin
        emit       = 1'b1;
        emit_pixel = stk_q;
        state_nxt  = S_IDLE;
      end

      S_CHECK: begin
        if (cnt_r < CNW'(cw_r)) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
          if (term_r) begin
            ended_nxt   = 1'b1;
            emit_status = ST_END;
          end else begin
            emit_status = ST_NEED;
          end
        end else begin
          buf_ra    = pos_r[PW-1:3];
          ba_nxt    = next_byte(pos_r[PW-1:3]);
          fcnt_nxt  = 2'd0;
          state_nxt = S_FETCH;
        end
      end

      // Collect three consecutive bytes, oldest ending in the low bits.
      S_FETCH: begin
        win_nxt  = {buf_q, win_r[23:8]};
        ba_nxt   = next_byte(ba_r);
        fcnt_nxt = fcnt_r + 2'd1;
        if (fcnt_r == 2'd2) state_nxt = S_CODE;
      end

      S_CODE: begin
        pos_nxt = psum[PW-1:0];
        cnt_nxt = cnt_r - CNW'(cw_r);
        if (code_c == clear_r) begin
          cw_nxt    = root_r + 4'd1;
          nf_nxt    = clear_r + NW'(2);
          lim_nxt   = clear_r << 1;
          sp_nxt    = '0;
          fresh_nxt = 1'b1;
          state_nxt = S_CHECK;
        end else if (code_c == clear_r + NW'(1)) begin
          ended_nxt   = 1'b1;
          emit        = 1'b1;
          emit_status = ST_END;
          state_nxt   = S_IDLE;
        end else if (fresh_r) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
          if (code_c > clear_r) begin
            ended_nxt   = 1'b1;
            sp_nxt      = '0;
            emit_status = ST_CORRUPT;
          end else begin
            fresh_nxt  = 1'b0;
            first_nxt  = code_c[7:0];
            prev_nxt   = CDW'(code_c);
            emit_pixel = code_c[7:0];
          end
        end else if (code_c > nf_r) begin
          ended_nxt   = 1'b1;
          sp_nxt      = '0;
          emit        = 1'b1;
          emit_status = ST_CORRUPT;
          state_nxt   = S_IDLE;
        end else begin
          incode_nxt = CDW'(code_c);
          state_nxt  = S_WALK_CHK;
          if (code_c == nf_r) begin
            // Code not yet in the table: it ends with the first symbol.
            stk_we = 1'b1;
            stk_wa = '0;
            sp_nxt = NW'(1);
            wc_nxt = prev_r;
          end else begin
            sp_nxt = '0;
            wc_nxt = CDW'(code_c);
          end
        end
      end

      S_WALK_CHK: begin
        if (sp_r >= NW'(TBL)) begin
          ended_nxt   = 1'b1;
          sp_nxt      = '0;
          emit        = 1'b1;
          emit_status = ST_CORRUPT;
          state_nxt   = S_IDLE;
        end else if (wc_ext >= clear_r) begin
          tbl_ra    = wc_r;
          state_nxt = S_WALK;
        end else begin
          // Root reached: it is the first symbol and the pixel returned now.
          first_nxt  = wc_r[7:0];
          emit       = 1'b1;
          emit_pixel = wc_r[7:0];
          prev_nxt   = incode_r;
          state_nxt  = S_IDLE;
          if (nf_r < NW'(TBL)) begin
            tbl_we = 1'b1;
            nf_nxt = nf_inc;
            if (nf_inc >= lim_r && lim_r < NW'(TBL)) begin
              lim_nxt = lim_r << 1;
              cw_nxt  = cw_r + 4'd1;
            end
          end
        end
      end

      // One chain link a cycle: push the suffix, follow the prefix.
      S_WALK: begin
        stk_we = 1'b1;
        stk_wd = suf_q;
        sp_nxt = sp_r + 1'b1;
        wc_nxt = pre_q;
        tbl_ra = pre_q;
        if (!(pre_ext >= clear_r && (sp_r + 1'b1) < NW'(TBL))) begin
          state_nxt = S_WALK_CHK;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      root_r      <= ROOT_RESET;
      clear_r     <= NW'(1) << ROOT_RESET;
      cw_r        <= ROOT_RESET + 4'd1;
      nf_r        <= (NW'(1) << ROOT_RESET) + NW'(2);
      lim_r       <= NW'(1) << (ROOT_RESET + 4'd1);
      first_r     <= 8'd0;
      prev_r      <= '0;
      fresh_r     <= 1'b1;
      ended_r     <= 1'b0;
      term_r      <= 1'b0;
      left_r      <= 8'd0;
      pos_r       <= '0;
      cnt_r       <= '0;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      root_r  <= root_nxt;
      clear_r <= clear_nxt;
      cw_r    <= cw_nxt;
      nf_r    <= nf_nxt;
      lim_r   <= lim_nxt;
      first_r <= first_nxt;
      prev_r  <= prev_nxt;
      fresh_r <= fresh_nxt;
      ended_r <= ended_nxt;
      term_r  <= term_nxt;
      left_r  <= left_nxt;
      pos_r   <= pos_nxt;
      cnt_r   <= cnt_nxt;
      sp_r    <= sp_nxt;
      if (emit)            out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // Working registers and the result register.
  always_ff @(posedge clk) begin
    wc_r     <= wc_nxt;
    incode_r <= incode_nxt;
    win_r    <= win_nxt;
    fcnt_r   <= fcnt_nxt;
    ba_r     <= ba_nxt;
    if (emit) begin
      out_status_r <= emit_status;
      out_pixel_r  <= emit_pixel;
    end
  end

  // Code table.
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      prefix_mem[tbl_wa] <= prev_r;
      suffix_mem[tbl_wa] <= wc_r[7:0];
    end
    pre_q <= prefix_mem[tbl_ra];
    suf_q <= suffix_mem[tbl_ra];
  end

  // Reversal stack.
  always_ff @(posedge clk) begin
    if (stk_we) stack_mem[stk_wa] <= stk_wd;
    stk_q <= stack_mem[stk_ra];
  end

  // Bit buffer bytes.
  always_ff @(posedge clk) begin
    if (buf_we) buf_mem[buf_wa] <= cmd.data;
    buf_q <= buf_mem[buf_ra];
  end

  assign out_tvalid = out_valid_r;
  assign out_status = out_status_r;
  assign out_pixel  = out_pixel_r;

  sp_bound: assert property (@(posedge clk) disable iff (!rst_n) sp_r <= NW'(TBL))
    else $error("stack pointer beyond table depth");
  cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= CNW'(BBITS))
    else $error("bit count beyond buffer size");
  ended_empty: assert property (@(posedge clk) disable iff (!rst_n) ended_r |-> sp_r == '0)
    else $error("stack not empty after image end");
  pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> state_r == S_IDLE)
    else $error("command taken while a request is in progress");

endmodule
`default_nettype wire
